// ===== rtl/dtsb_pkg.sv =====
// Package for double_to_sortable_bytes: field widths, encoding constants, kind enum and stage structs.
// No dependencies.
package dtsb_pkg;
    localparam int unsigned BitsW = 64;
    localparam logic [10:0] ExpAllOnes = 11'h7ff;
    localparam logic [7:0] LeadZero = 8'h80;
    localparam logic [7:0] LeadPos = 8'he0;
    localparam logic [7:0] EnegFlip = 8'h60;
    localparam logic [7:0] ShortFlag = 8'h20;
    localparam logic [7:0] ShortMask = 8'h1c;
    localparam logic [7:0] LongMask = 8'h1f;
    localparam logic [7:0] LowMask = 8'hfc;
    localparam int unsigned SubBias = 1073;
    localparam int unsigned NormBias = 1022;

    typedef enum logic [1:0] {
        K_NEGINF = 2'd0,
        K_POSINF = 2'd1,
        K_ZERO   = 2'd2,
        K_FINITE = 2'd3
    } t_kind;

    // stage 1 -> stage 2
    typedef struct packed {
        t_kind       kind;
        logic        neg;
        logic [52:0] sig;
        logic [11:0] e;      // signed exponent e (frexp)
    } t_norm;

    // stage 2 -> stage 3
    typedef struct packed {
        t_kind       kind;
        logic        neg;
        logic        longf;
        logic [7:0]  b0;
        logic [7:0]  nx;
        logic [25:0] w1;
        logic [31:0] w2;
    } t_enc;
endpackage

// ===== rtl/dtsb_norm.sv =====
// Stage 1: classify the binary64 pattern and normalize subnormals.
// Depends on dtsb_pkg.
module dtsb_norm import dtsb_pkg::*; (
    input  logic [BitsW-1:0] i_bits,
    output t_norm            o_norm
);
    logic        neg;
    logic [10:0] bexp;
    logic [51:0] frac;
    logic [5:0]  p;

    always_comb begin
        neg  = i_bits[63];
        bexp = i_bits[62:52];
        frac = i_bits[51:0];
        p    = 6'd0;
        for (int k = 0; k < 52; k++) begin
            if (frac[k]) p = 6'(k);
        end
        o_norm.neg = neg;
        if (bexp == ExpAllOnes) begin
            o_norm.kind = (frac == 52'd0 && neg) ? K_NEGINF : K_POSINF;
        end else if (bexp == 11'd0 && frac == 52'd0) begin
            o_norm.kind = K_ZERO;
        end else begin
            o_norm.kind = K_FINITE;
        end
        if (bexp == 11'd0) begin
            o_norm.sig = 53'({1'b0, frac} << (6'd52 - p));
            o_norm.e   = 12'({6'd0, p}) - 12'(SubBias);
        end else begin
            o_norm.sig = {1'b1, frac};
            o_norm.e   = 12'({1'b0, bexp}) - 12'(NormBias);
        end
    end
endmodule

// ===== rtl/dtsb_enc.sv =====
// Stage 2: exponent header bytes and mantissa words (negated for negatives).
// Depends on dtsb_pkg.
module dtsb_enc import dtsb_pkg::*; (
    input  t_norm i_norm,
    output t_enc  o_enc
);
    logic [11:0] x, ax;
    logic        eneg, flip;
    logic [7:0]  nx;
    logic [31:0] a1, a2;

    always_comb begin
        x    = i_norm.e - 12'd8;
        eneg = x[11];
        ax   = eneg ? (12'd0 - x) : x;
        flip = i_norm.neg ^ eneg;
        nx   = i_norm.neg ? 8'h00 : LeadPos;
        if (eneg) nx = nx ^ EnegFlip;
        o_enc.kind = i_norm.kind;
        o_enc.neg  = i_norm.neg;
        o_enc.b0   = 8'h00;
        if (ax < 12'd8) begin
            o_enc.longf = 1'b0;
            nx = (nx ^ ShortFlag) | {3'd0, ax[2:0], 2'd0};
            if (flip) nx = nx ^ ShortMask;
        end else begin
            o_enc.longf = 1'b1;
            o_enc.b0 = nx | {3'd0, ax[10:6]};
            if (flip) o_enc.b0 = o_enc.b0 ^ LongMask;
            nx = {ax[5:0], 2'd0};
            if (flip) nx = nx ^ LowMask;
        end
        o_enc.nx = nx;
        if (i_norm.neg) begin
            a1 = 32'(i_norm.sig[52:27]);
            a2 = {i_norm.sig[26:0], 5'd0};
            a1 = 32'd0 - a1 + ((a2 != 32'd0) ? 32'd1 : 32'd0);
            a2 = 32'd0 - a2;
        end else begin
            a1 = 32'(i_norm.sig[52:26]);
            a2 = {i_norm.sig[25:0], 6'd0};
        end
        o_enc.w1 = a1[25:0];
        o_enc.w2 = a2;
    end
endmodule

// ===== rtl/dtsb_pack.sv =====
// Stage 3: assemble the byte string and drop trailing zero bytes.
// Depends on dtsb_pkg.
module dtsb_pack import dtsb_pkg::*; (
    input  t_enc        i_enc,
    output logic [3:0]  o_count,
    output logic [7:0]  o_lead,
    output logic [63:0] o_tail
);
    logic [71:0] s;
    logic [3:0]  len;

    always_comb begin
        s   = 72'd0;
        len = 4'd0;
        case (i_enc.kind)
            K_NEGINF: len = 4'd0;
            K_POSINF: begin
                s   = '1;
                len = 4'd9;
            end
            K_ZERO: begin
                s   = {LeadZero, 64'd0};
                len = 4'd1;
            end
            K_FINITE: begin
                if (i_enc.longf) begin
                    s = {i_enc.b0, i_enc.nx | {6'd0, i_enc.w1[25:24]},
                         i_enc.w1[23:0], i_enc.w2};
                end else begin
                    s = {i_enc.nx | {6'd0, i_enc.w1[25:24]},
                         i_enc.w1[23:0], i_enc.w2, 8'd0};
                end
                for (int k = 0; k < 9; k++) begin
                    if (s[8*k +: 8] != 8'd0 && len == 4'd0) len = 4'(9 - k);
                end
            end
            default: len = 4'd0;
        endcase
        o_count = len;
        o_lead  = s[71:64];
        o_tail  = s[63:0];
    end
endmodule

// ===== rtl/double_to_sortable_bytes.sv =====
// Top level: three-stage pipeline turning a binary64 pattern into an order-preserving
// byte string. Depends on dtsb_pkg, dtsb_norm, dtsb_enc, dtsb_pack.
//
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_stall  | i_value_bits[63:0]
//  output  | out       | o_valid / i_stall  | o_byte_count, o_lead_byte, o_tail_bytes
//
// One transaction per cycle sustained while the output is not stalled; the stages are
// classify and normalize, header and mantissa negation, byte packing and trimming.
// Synchronous active-low reset clears the stage valid bits only.
// A stall on the output holds every full stage with only full stages below it; an empty
// stage still fills, so bubbles collapse. o_stall is combinational from i_stall.
module double_to_sortable_bytes import dtsb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [BitsW-1:0] i_value_bits,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [3:0]       o_byte_count,
    output logic [7:0]       o_lead_byte,
    output logic [63:0]      o_tail_bytes
);
    logic [BitsW-1:0] r_bits;
    t_norm            r_norm, n_norm;
    t_enc             r_enc, n_enc;
    logic [3:0]       n_count;
    logic [7:0]       n_lead;
    logic [63:0]      n_tail;
    logic             r_v0, r_v1, r_v2;
    logic             adv2, adv1, adv0;

    // per-stage advance: move when downstream frees or is empty
    assign adv2 = !r_v2 || !i_stall;
    assign adv1 = !r_v1 || adv2;
    assign adv0 = !r_v0 || adv1;
    assign o_stall = !adv0;

    dtsb_norm u_norm (.i_bits(r_bits), .o_norm(n_norm));
    dtsb_enc  u_enc  (.i_norm(r_norm), .o_enc(n_enc));
    dtsb_pack u_pack (.i_enc(r_enc), .o_count(n_count), .o_lead(n_lead), .o_tail(n_tail));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            if (adv0) r_v0 <= i_valid;
            if (adv1) r_v1 <= r_v0;
            if (adv2) r_v2 <= r_v1;
        end
        if (adv0) r_bits <= i_value_bits;
        if (adv1) r_norm <= n_norm;
        if (adv2) r_enc  <= n_enc;
    end

    // output register lives in stage 3 as r_enc; packing is the last logic level
    assign o_valid      = r_v2;
    assign o_byte_count = n_count;
    assign o_lead_byte  = n_lead;
    assign o_tail_bytes = n_tail;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_tail_bytes))
        else $error("stalled result changed");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_byte_count <= 4'd9)
        else $error("byte count out of range");
    a_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_byte_count == 4'd0 |-> o_lead_byte == 8'd0 && o_tail_bytes == 64'd0)
        else $error("empty string not zero");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v2 |-> !o_stall)
        else $error("stall with empty output stage");
endmodule

// ===== tb/sv/double_to_sortable_bytes_tb.sv =====
// Testbench for double_to_sortable_bytes: drives binary64 patterns, predicts the
// sortable byte string of each and checks it. Depends on dtsb_pkg and the block.
module double_to_sortable_bytes_tb import dtsb_pkg::*; ();

    typedef struct packed {
        logic [3:0]  count;
        logic [7:0]  lead;
        logic [63:0] tail;
    } t_bytes;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [BitsW-1:0] value_bits;
    logic             out_valid;
    logic             out_stall;
    logic [3:0]       byte_count;
    logic [7:0]       lead_byte;
    logic [63:0]      tail_bytes;

    logic [63:0] pending_values[$];
    t_bytes      expected_bytes[$];
    int          mismatches = 0;
    int          send_idle_pct = 17;
    int          recv_idle_pct = 51;
    int          hold_cycles = 0;   // receiver hold-off countdown
    bit          send_pause = 0;    // sender pauses until drained

    double_to_sortable_bytes i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(out_stall), .i_value_bits(value_bits),
        .o_valid(out_valid), .i_stall(in_stall),
        .o_byte_count(byte_count), .o_lead_byte(lead_byte), .o_tail_bytes(tail_bytes)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Encoding predictor: frexp split, header byte(s), 26+32-bit mantissa, trim.
    function automatic t_bytes encode_sortable(input logic [63:0] v);
        logic        neg;
        logic [10:0] bexp;
        logic [51:0] frac;
        logic [7:0]  b[9];
        int          len;
        logic [52:0] sig;
        int          e, x, ax, p;
        logic        eneg, flip;
        logic [7:0]  nx;
        logic [31:0] w1, w2;
        t_bytes      r;
        neg = v[63];
        bexp = v[62:52];
        frac = v[51:0];
        len = 0;
        for (int i = 0; i < 9; i++) b[i] = 8'h00;
        if (bexp == ExpAllOnes) begin
            if (frac == 0 && neg) begin
                len = 0;
            end else begin
                for (int i = 0; i < 9; i++) b[i] = 8'hff;
                len = 9;
            end
        end else if (bexp == 0 && frac == 0) begin
            b[0] = LeadZero;
            len = 1;
        end else begin
            if (bexp == 0) begin
                p = 0;
                for (int i = 0; i < 52; i++) if (frac[i]) p = i;
                sig = {1'b0, frac} << (52 - p);
                e = p - SubBias;
            end else begin
                sig = {1'b1, frac};
                e = int'(bexp) - NormBias;
            end
            nx = neg ? 8'h00 : LeadPos;
            x = e - 8;
            eneg = x < 0;
            ax = eneg ? -x : x;
            if (eneg) nx ^= EnegFlip;
            flip = neg != eneg;
            if (ax < 8) begin
                nx ^= ShortFlag;
                nx |= 8'(ax << 2);
                if (flip) nx ^= ShortMask;
            end else begin
                nx |= 8'((ax >> 6) & 'h1f);
                if (flip) nx ^= LongMask;
                b[len++] = nx;
                nx = 8'((ax << 2) & 'hff);
                if (flip) nx ^= LowMask;
            end
            if (neg) begin
                w1 = 32'(sig >> 27);
                w2 = {sig[26:0], 5'b0};
                w1 = -w1;
                if (w2 != 0) w1 += 1;
                w2 = -w2;
            end else begin
                w1 = 32'(sig >> 26);
                w2 = {sig[25:0], 6'b0};
            end
            w1 &= 32'h03ffffff;
            b[len++] = nx | w1[31:24];
            b[len++] = w1[23:16];
            b[len++] = w1[15:8];
            b[len++] = w1[7:0];
            b[len++] = w2[31:24];
            b[len++] = w2[23:16];
            b[len++] = w2[15:8];
            b[len++] = w2[7:0];
            while (len > 0 && b[len-1] == 0) len--;
        end
        r.count = 4'(len);
        r.lead = b[0];
        r.tail = 0;
        for (int i = 1; i < 9; i++) r.tail = {r.tail[55:0], b[i]};
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        mismatches++;
    endtask

    // Driver: next pending value offered at the falling edge; held while stalled.
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 0;
        end else if (!(in_valid && out_stall)) begin
            if (pending_values.size() > 0 && !send_pause &&
                $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1;
                value_bits <= pending_values.pop_front();
            end else begin
                in_valid <= 0;
            end
        end
    end

    // Receiver stall: a long hold-off overrides the random idling.
    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            in_stall <= 1;
        end else begin
            in_stall <= $urandom_range(99) < recv_idle_pct;
        end
    end

    // Input monitor: each accepted transaction yields one expectation.
    always @(posedge clk) begin
        if (rst_n && in_valid && !out_stall)
            expected_bytes.push_back(encode_sortable(value_bits));
    end

    // Output monitor: compare against the oldest expectation.
    always @(posedge clk) begin
        t_bytes want;
        if (rst_n && out_valid && !in_stall) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch("unexpected result", 64'(byte_count), 64'd0);
            end else begin
                want = expected_bytes.pop_front();
                if (byte_count != want.count)
                    report_mismatch("byte_count", 64'(byte_count), 64'(want.count));
                if (lead_byte != want.lead)
                    report_mismatch("lead_byte", 64'(lead_byte), 64'(want.lead));
                if (tail_bytes != want.tail)
                    report_mismatch("tail_bytes", tail_bytes, want.tail);
            end
        end
    end

    function automatic logic [63:0] random_double();
        logic [63:0] v;
        logic [10:0] ex;
        v = {$urandom, $urandom};
        case ($urandom_range(9))
            0: ex = 0;                                   // subnormal or zero
            1: ex = ExpAllOnes;                          // inf / NaN
            2: ex = 11'($urandom_range(1022 - 8, 1022 + 9)); // short and nearby long exponent forms
            default: ex = v[62:52];
        endcase
        v[62:52] = ex;
        if ($urandom_range(7) == 0) v[51:0] = 52'(1) << $urandom_range(51);
        if ($urandom_range(15) == 0) v[51:0] = 0;
        return v;
    endfunction

    task automatic wait_drained();
        while (pending_values.size() > 0 || in_valid || expected_bytes.size() > 0)
            @(posedge clk);
    endtask

    initial begin
        rst_n = 0;
        in_valid = 0;
        in_stall = 0;
        value_bits = 0;
        repeat (7) @(posedge clk);
        @(negedge clk) rst_n = 1;

        // Directed: infinities, NaNs, zeros, subnormal extremes, short/long exponents.
        pending_values.push_back(64'hfff0000000000000);
        pending_values.push_back(64'h7ff0000000000000);
        pending_values.push_back(64'h7ff8000000000001);
        pending_values.push_back(64'hffffffffffffffff);
        pending_values.push_back(64'h0000000000000000);
        pending_values.push_back(64'h8000000000000000);
        pending_values.push_back(64'h0000000000000001);
        pending_values.push_back(64'h8000000000000001);
        pending_values.push_back(64'h000fffffffffffff);
        pending_values.push_back(64'h800fffffffffffff);
        pending_values.push_back(64'h0010000000000000);
        pending_values.push_back(64'h7fefffffffffffff);
        pending_values.push_back(64'hffefffffffffffff);
        pending_values.push_back(64'h3ff0000000000000);
        pending_values.push_back(64'hbff0000000000000);
        pending_values.push_back(64'h4060000000000000);
        pending_values.push_back(64'h4070000000000000);
        pending_values.push_back(64'h3f70000000000000);
        pending_values.push_back(64'hbf70000000000000);
        pending_values.push_back(64'h3fe0000000000000);
        pending_values.push_back(64'h5555555555555555);
        pending_values.push_back(64'haaaaaaaaaaaaaaaa);
        for (int i = 0; i < 130; i++) pending_values.push_back(random_double());

        // Long receiver hold-off while the sender keeps offering.
        repeat (20) @(posedge clk);
        hold_cycles = 60;
        wait_drained();

        // Swap idling mix; midway the sender pauses until every result is back.
        send_idle_pct = 51;
        recv_idle_pct = 17;
        for (int i = 0; i < 130; i++) pending_values.push_back(random_double());
        repeat (40) @(posedge clk);
        send_pause = 1;
        while (in_valid || expected_bytes.size() > 0) @(posedge clk);
        repeat (5) @(posedge clk);
        send_pause = 0;
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 130; i++) pending_values.push_back(random_double());
        wait_drained();
        repeat (10) @(posedge clk);

        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #200000;
        $display("FAILURE");
        $finish;
    end
endmodule
